>>> src/cvbf_pkg.sv
// ----------------------------------------------------------------------------
// cvbf_pkg
// Shared types and codes for the cut vertex and bridge finder.
// ----------------------------------------------------------------------------
package cvbf_pkg;

    localparam int VID_W   = 6;   // vertex id field width
    localparam int TIME_W  = 7;   // discovery time / low link width
    localparam int CFG_W   = 7;   // widest configuration register

    localparam logic [TIME_W-1:0] PARENT_NONE = 7'h7F;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_CUT    = 2'd0;
    localparam logic [1:0] KIND_BRIDGE = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_SEARCH_MODE  = 1'b1;

    // per-vertex search record
    typedef struct packed {
        logic              cut;
        logic [TIME_W-1:0] parent;
        logic [TIME_W-1:0] low;
        logic [TIME_W-1:0] disc;
    } vrec_t;

    localparam int VREC_W = 1 + 3 * TIME_W;

endpackage

>>> src/cut_vertex_and_bridge_finder.sv
// ----------------------------------------------------------------------------
// cut_vertex_and_bridge_finder
// Loads undirected edges into adjacency lists and runs an iterative DFS that
// reports cut vertices or bridges.
// ----------------------------------------------------------------------------
// Edges go to the head of each endpoint's list in a slot RAM; per-vertex heads,
// search records and the walk stack sit in small RAMs with registered reads.
// An add edge writes one slot, or two when its endpoints differ. A run walks
// the adjacency slots from each unvisited root, pushing on a tree edge and
// popping when a list runs out (the pop reads the stack and then the parent's
// record in turn); in cut vertex mode a scan of every vertex's record follows.
// The single read port of each RAM puts these reads one after another. The
// next item is taken once the last result of a run has been handed to the
// output register, and m_last marks the final result item of each run.
// ----------------------------------------------------------------------------
module cut_vertex_and_bridge_finder #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_SLOTS    = 512
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [cvbf_pkg::CFG_W-1:0]  cfg_data,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [cvbf_pkg::VID_W-1:0]  s_vertex_u,
    input  logic [cvbf_pkg::VID_W-1:0]  s_vertex_v,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_kind,
    output logic [cvbf_pkg::VID_W-1:0]  m_first_vertex,
    output logic [cvbf_pkg::VID_W-1:0]  m_second_vertex,
    output logic                        m_last
);

    localparam int VW   = cvbf_pkg::VID_W;
    localparam int TW   = cvbf_pkg::TIME_W;
    localparam int SW   = $clog2(MAX_SLOTS + 1);
    localparam int SAW  = $clog2(MAX_SLOTS);
    localparam int VAW  = $clog2(MAX_VERTICES);
    localparam int DW   = $clog2(MAX_VERTICES + 1);
    localparam logic [SW-1:0] SLOT_NULL = SW'(MAX_SLOTS);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_ADD_A  = 5'd1;
    localparam logic [4:0] ST_ADD_B  = 5'd2;
    localparam logic [4:0] ST_ROOT   = 5'd3;
    localparam logic [4:0] ST_ROOTH  = 5'd4;
    localparam logic [4:0] ST_WALK   = 5'd5;
    localparam logic [4:0] ST_W1     = 5'd6;
    localparam logic [4:0] ST_W2     = 5'd7;
    localparam logic [4:0] ST_PUSH   = 5'd8;
    localparam logic [4:0] ST_POP2   = 5'd9;
    localparam logic [4:0] ST_POP3   = 5'd10;
    localparam logic [4:0] ST_EMIT   = 5'd11;
    localparam logic [4:0] ST_SCANRD = 5'd12;
    localparam logic [4:0] ST_SCANCK = 5'd13;
    localparam logic [4:0] ST_DONE   = 5'd14;
    localparam logic [4:0] ST_FLUSH  = 5'd15;

    logic [4:0]  state_reg, ret_reg;
    logic [6:0]  vcount_reg;
    logic        mode_reg;

    logic [MAX_VERTICES-1:0] hvalid_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [SW-1:0]  fill_reg;
    logic [VW-1:0]  u_reg, v_reg;
    logic [VAW-1:0] hra_reg;

    logic [6:0]     r_reg;
    logic [DW-1:0]  depth_reg;
    logic [DW-1:0]  rootch_reg;
    logic [TW-1:0]  time_reg;
    logic [VW-1:0]  top_v_reg;
    logic [SW-1:0]  top_c_reg;
    logic [TW-1:0]  cur_disc_reg, cur_low_reg, cur_par_reg;
    logic           cur_cut_reg;
    logic [TW-1:0]  child_low_reg;
    logic [VW-1:0]  child_v_reg;

    logic [1:0]     em_kind_reg;
    logic [VW-1:0]  em_a_reg, em_b_reg;
    logic           pend_v_reg;
    logic [1:0]     pend_kind_reg;
    logic [VW-1:0]  pend_a_reg, pend_b_reg;

    logic           m_valid_reg, m_last_reg;
    logic [1:0]     m_kind_reg;
    logic [VW-1:0]  m_a_reg, m_b_reg;

    // RAM ports
    logic            h_we;
    logic [VAW-1:0]  h_waddr, h_raddr;
    logic [SW-1:0]   h_q;
    logic            s_we;
    logic [SAW-1:0]  s_waddr;
    logic [VW+SW-1:0] s_wdata, s_q;
    logic            v_we;
    logic [VAW-1:0]  v_waddr, v_raddr;
    logic [cvbf_pkg::VREC_W-1:0] v_wdata, v_q;
    logic            k_we;
    logic [VAW-1:0]  k_waddr, k_raddr;
    logic [VW+SW-1:0] k_wdata, k_q;

    logic [6:0]      live_n;
    logic [SW:0]     need_fill;
    logic            fits;
    logic [SW-1:0]   head_val;
    logic [VW-1:0]   slot_tgt;
    logic [SW-1:0]   slot_nxt;
    cvbf_pkg::vrec_t cur_rec, rd_rec;
    logic            out_free;
    logic [TW-1:0]   p_low_new;

    assign live_n    = (vcount_reg > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_reg;
    assign need_fill = {1'b0, fill_reg} + ((s_vertex_u == s_vertex_v) ? (SW+1)'(1) : (SW+1)'(2));
    assign fits      = ({1'b0, s_vertex_u} < live_n) && ({1'b0, s_vertex_v} < live_n)
                       && (need_fill <= (SW+1)'(MAX_SLOTS));
    assign head_val  = hvalid_reg[hra_reg] ? h_q : SLOT_NULL;
    assign slot_tgt  = s_q[VW+SW-1:SW];
    assign slot_nxt  = s_q[SW-1:0];
    assign rd_rec    = cvbf_pkg::vrec_t'(v_q);
    assign cur_rec   = '{cut: cur_cut_reg, parent: cur_par_reg, low: cur_low_reg,
                         disc: cur_disc_reg};
    assign out_free  = !m_valid_reg || m_ready;
    assign p_low_new = (child_low_reg < rd_rec.low) ? child_low_reg : rd_rec.low;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_first_vertex  = m_a_reg;
    assign m_second_vertex = m_b_reg;
    assign m_last          = m_last_reg;

    always_comb begin
        h_we    = 1'b0;
        h_waddr = u_reg[VAW-1:0];
        h_raddr = hra_reg;
        s_we    = 1'b0;
        s_waddr = fill_reg[SAW-1:0];
        s_wdata = {v_reg, head_val};
        v_we    = 1'b0;
        v_waddr = top_v_reg[VAW-1:0];
        v_wdata = cvbf_pkg::VREC_W'(cur_rec);
        v_raddr = slot_tgt[VAW-1:0];
        k_we    = 1'b0;
        k_waddr = 7'(depth_reg - DW'(1)) > 7'd0 ? VAW'(depth_reg - DW'(1))
                                                : VAW'(depth_reg - DW'(1));
        k_wdata = {top_v_reg, slot_nxt};
        k_raddr = VAW'(depth_reg - DW'(2));
        unique case (state_reg)
            ST_IDLE: begin
                h_raddr = s_vertex_u[VAW-1:0];
            end
            ST_ADD_A: begin
                h_we    = 1'b1;
                s_we    = 1'b1;
                h_raddr = v_reg[VAW-1:0];
            end
            ST_ADD_B: begin
                h_we    = 1'b1;
                h_waddr = v_reg[VAW-1:0];
                s_we    = 1'b1;
                s_wdata = {u_reg, head_val};
            end
            ST_ROOT: begin
                h_raddr = r_reg[VAW-1:0];
            end
            ST_WALK: begin
                // pop writes back the finished vertex
                v_we = (top_c_reg == SLOT_NULL);
            end
            ST_W1: begin
                h_raddr = slot_tgt[VAW-1:0];
                if (({1'b0, slot_tgt} < live_n) && !visited_reg[slot_tgt[VAW-1:0]]
                        && (depth_reg < DW'(MAX_VERTICES))) begin
                    v_we = 1'b1;
                    k_we = 1'b1;
                end
            end
            ST_POP2: begin
                v_raddr = k_q[SW+VAW-1:SW];
            end
            ST_SCANRD: begin
                v_raddr = r_reg[VAW-1:0];
            end
            default: begin
            end
        endcase
    end

    cvbf_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_head (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(fill_reg),
        .raddr(h_raddr), .rdata(h_q)
    );

    cvbf_ram #(.WIDTH(VW + SW), .DEPTH(MAX_SLOTS)) u_slot (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(top_c_reg[SAW-1:0]), .rdata(s_q)
    );

    cvbf_ram #(.WIDTH(cvbf_pkg::VREC_W), .DEPTH(MAX_VERTICES)) u_vrec (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_q)
    );

    cvbf_ram #(.WIDTH(VW + SW), .DEPTH(MAX_VERTICES)) u_stack (
        .aclk(aclk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            vcount_reg  <= '0;
            mode_reg    <= 1'b0;
            hvalid_reg  <= '0;
            visited_reg <= '0;
            fill_reg    <= '0;
            depth_reg   <= '0;
            time_reg    <= '0;
            rootch_reg  <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            hra_reg <= h_raddr;
            if (cfg_we) begin
                if (cfg_index == cvbf_pkg::REG_VERTEX_COUNT) begin
                    vcount_reg <= cfg_data;
                end else begin
                    mode_reg <= cfg_data[0];
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        u_reg <= s_vertex_u;
                        v_reg <= s_vertex_v;
                        priority case (s_opcode)
                            cvbf_pkg::OP_ADD: begin
                                if (fits) begin
                                    state_reg <= ST_ADD_A;
                                end
                            end
                            cvbf_pkg::OP_RUN: begin
                                visited_reg <= '0;
                                time_reg    <= '0;
                                depth_reg   <= '0;
                                r_reg       <= '0;
                                state_reg   <= ST_ROOT;
                            end
                            cvbf_pkg::OP_CLEAR: begin
                                hvalid_reg <= '0;
                                fill_reg   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ADD_A: begin
                    hvalid_reg[u_reg[VAW-1:0]] <= 1'b1;
                    fill_reg  <= fill_reg + SW'(1);
                    state_reg <= (u_reg != v_reg) ? ST_ADD_B : ST_IDLE;
                end
                ST_ADD_B: begin
                    hvalid_reg[v_reg[VAW-1:0]] <= 1'b1;
                    fill_reg  <= fill_reg + SW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_ROOT: begin
                    if (r_reg >= live_n) begin
                        r_reg     <= '0;
                        state_reg <= mode_reg ? ST_DONE : ST_SCANRD;
                    end else if (visited_reg[r_reg[VAW-1:0]]) begin
                        r_reg <= r_reg + 7'd1;
                    end else begin
                        state_reg <= ST_ROOTH;
                    end
                end
                ST_ROOTH: begin
                    visited_reg[r_reg[VAW-1:0]] <= 1'b1;
                    time_reg     <= time_reg + TW'(1);
                    top_v_reg    <= r_reg[VW-1:0];
                    top_c_reg    <= head_val;
                    cur_disc_reg <= time_reg + TW'(1);
                    cur_low_reg  <= time_reg + TW'(1);
                    cur_par_reg  <= cvbf_pkg::PARENT_NONE;
                    cur_cut_reg  <= 1'b0;
                    rootch_reg   <= '0;
                    depth_reg    <= DW'(1);
                    state_reg    <= ST_WALK;
                end
                ST_WALK: begin
                    if (top_c_reg == SLOT_NULL) begin
                        depth_reg <= depth_reg - DW'(1);
                        if (depth_reg == DW'(1)) begin
                            r_reg     <= r_reg + 7'd1;
                            state_reg <= ST_ROOT;
                        end else begin
                            child_low_reg <= cur_low_reg;
                            child_v_reg   <= top_v_reg;
                            state_reg     <= ST_POP2;
                        end
                    end else begin
                        state_reg <= ST_W1;
                    end
                end
                ST_W1: begin
                    top_c_reg <= slot_nxt;
                    v_reg     <= slot_tgt;
                    state_reg <= ST_WALK;
                    if ({1'b0, slot_tgt} < live_n) begin
                        if (!visited_reg[slot_tgt[VAW-1:0]]) begin
                            if (depth_reg < DW'(MAX_VERTICES)) begin
                                state_reg <= ST_PUSH;
                            end
                        end else if (({1'b0, slot_tgt} != cur_par_reg)
                                     && (slot_tgt != top_v_reg)) begin
                            state_reg <= ST_W2;
                        end
                    end
                end
                ST_W2: begin
                    if (rd_rec.disc < cur_low_reg) begin
                        cur_low_reg <= rd_rec.disc;
                    end
                    state_reg <= ST_WALK;
                end
                ST_PUSH: begin
                    visited_reg[v_reg[VAW-1:0]] <= 1'b1;
                    time_reg     <= time_reg + TW'(1);
                    cur_par_reg  <= {1'b0, top_v_reg};
                    top_v_reg    <= v_reg;
                    top_c_reg    <= head_val;
                    cur_disc_reg <= time_reg + TW'(1);
                    cur_low_reg  <= time_reg + TW'(1);
                    cur_cut_reg  <= 1'b0;
                    depth_reg    <= depth_reg + DW'(1);
                    state_reg    <= ST_WALK;
                end
                ST_POP2: begin
                    top_v_reg <= k_q[VW+SW-1:SW];
                    top_c_reg <= k_q[SW-1:0];
                    state_reg <= ST_POP3;
                end
                ST_POP3: begin
                    cur_disc_reg <= rd_rec.disc;
                    cur_par_reg  <= rd_rec.parent;
                    cur_low_reg  <= p_low_new;
                    cur_cut_reg  <= rd_rec.cut;
                    state_reg    <= ST_WALK;
                    if (!mode_reg) begin
                        if (rd_rec.parent == cvbf_pkg::PARENT_NONE) begin
                            rootch_reg <= rootch_reg + DW'(1);
                            if (rootch_reg != '0) begin
                                cur_cut_reg <= 1'b1;
                            end
                        end else if (child_low_reg >= rd_rec.disc) begin
                            cur_cut_reg <= 1'b1;
                        end
                    end else if (child_low_reg > rd_rec.disc) begin
                        em_kind_reg <= cvbf_pkg::KIND_BRIDGE;
                        em_a_reg    <= top_v_reg;
                        em_b_reg    <= child_v_reg;
                        ret_reg     <= ST_WALK;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold the newest result back so the final one can carry last
                    if (!pend_v_reg || out_free) begin
                        if (pend_v_reg) begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= pend_kind_reg;
                            m_a_reg     <= pend_a_reg;
                            m_b_reg     <= pend_b_reg;
                            m_last_reg  <= 1'b0;
                        end
                        pend_v_reg    <= 1'b1;
                        pend_kind_reg <= em_kind_reg;
                        pend_a_reg    <= em_a_reg;
                        pend_b_reg    <= em_b_reg;
                        state_reg     <= ret_reg;
                    end
                end
                ST_SCANRD: begin
                    state_reg <= (r_reg >= live_n) ? ST_DONE : ST_SCANCK;
                end
                ST_SCANCK: begin
                    r_reg     <= r_reg + 7'd1;
                    state_reg <= ST_SCANRD;
                    if (rd_rec.cut) begin
                        em_kind_reg <= cvbf_pkg::KIND_CUT;
                        em_a_reg    <= r_reg[VW-1:0];
                        em_b_reg    <= '0;
                        ret_reg     <= ST_SCANRD;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_DONE: begin
                    if (!pend_v_reg) begin
                        pend_v_reg    <= 1'b1;
                        pend_kind_reg <= cvbf_pkg::KIND_NONE;
                        pend_a_reg    <= '0;
                        pend_b_reg    <= '0;
                    end
                    state_reg <= ST_FLUSH;
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= pend_kind_reg;
                        m_a_reg     <= pend_a_reg;
                        m_b_reg     <= pend_b_reg;
                        m_last_reg  <= 1'b1;
                        pend_v_reg  <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_v_reg)
        else $error("result held back while idle");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_VERTICES))
        else $error("walk stack overflow");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= SLOT_NULL)
        else $error("slot store overfilled");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && out_free) |=> (m_valid && m_last && s_ready))
        else $error("run end not marked last");

endmodule

>>> src/cvbf_ram.sv
// ----------------------------------------------------------------------------
// cvbf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cvbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
